// ===== src/clipped_line_rasterizer_assert.svh =====
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_assert.svh
// Assertion macros used by the checker file clr_checker.sv.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_LINE_RASTERIZER_ASSERT_SVH
`define CLIPPED_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/clr_pkg.sv =====
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants of the clipped line rasteriser.
// ----------------------------------------------------------------------------
package clr_pkg;

    // display window, width 1 to 64, height 1 to 32
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;

    localparam int COORD_W = 8;
    localparam int ERR_W   = 11;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 40;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } clr_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch a new line request
        logic step;      // advance the walk by one pixel
        logic take;      // current pixel becomes the pending pixel
        logic push_pend; // pending pixel goes out, not last
        logic flush;     // final result of the line goes out
    } clr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic on_screen;
        logic at_end;
        logic pend_valid;
        logic slot_free;
    } clr_stat_t;

endpackage

// ===== src/clr_ctrl.sv =====
// ----------------------------------------------------------------------------
// clr_ctrl
// Sequencer of the line walk: load, walk, final flush.
// ----------------------------------------------------------------------------
module clr_ctrl
    import clr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  clr_stat_t stat,
    output clr_cmd_t  cmd
);

    clr_state_t state_reg;
    clr_state_t state_next;
    logic       stall;

    // a second on-screen pixel cannot be parked while the output slot is full
    assign stall = stat.on_screen && stat.pend_valid && !stat.slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!stall && stat.at_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (stat.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_WALK:
            begin
                cmd.step      = !stall && !stat.at_end;
                cmd.take      = !stall && stat.on_screen;
                cmd.push_pend = !stall && stat.on_screen && stat.pend_valid;
            end
            ST_FLUSH:
            begin
                cmd.flush = stat.slot_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/clr_datapath.sv =====
// ----------------------------------------------------------------------------
// clr_datapath
// Bresenham stepper, window test, pending pixel and output register.
// ----------------------------------------------------------------------------
module clr_datapath
    import clr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IN_W-1:0]   s_tdata,
    input  clr_cmd_t          cmd,
    output clr_stat_t         stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    // line request fields
    logic [COORD_W-1:0] in_sx;
    logic [COORD_W-1:0] in_sy;
    logic [COORD_W-1:0] in_ex;
    logic [COORD_W-1:0] in_ey;

    // load-time setup
    logic [COORD_W:0]   ddx;
    logic [COORD_W:0]   ddy;
    logic [COORD_W-1:0] dx_load;
    logic [COORD_W-1:0] dy_load;

    // walk state
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [COORD_W-1:0] xe_reg;
    logic [COORD_W-1:0] ye_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic               sx_neg_reg;
    logic               sy_neg_reg;
    logic [ERR_W-1:0]   err_reg;
    logic [23:0]        color_reg;

    logic [ERR_W-1:0]   err_next;
    logic [ERR_W:0]     e2;
    logic [ERR_W:0]     dx_ext;
    logic [ERR_W:0]     mdy_ext;
    logic               go_x;
    logic               go_y;

    // pending pixel: held back until it is known whether it is the last
    logic               pend_valid_reg;
    logic [10:0]        pend_xy_reg;

    // output slot
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic               out_user_reg;
    logic               out_last_reg;
    logic               slot_free;

    assign in_sx = s_tdata[7:0];
    assign in_sy = s_tdata[15:8];
    assign in_ex = s_tdata[23:16];
    assign in_ey = s_tdata[31:24];

    assign ddx     = {in_ex[7], in_ex} - {in_sx[7], in_sx};
    assign ddy     = {in_ey[7], in_ey} - {in_sy[7], in_sy};
    assign dx_load = ddx[COORD_W] ? COORD_W'(-ddx) : ddx[COORD_W-1:0];
    assign dy_load = ddy[COORD_W] ? COORD_W'(-ddy) : ddy[COORD_W-1:0];

    // error term decisions, both taken on the value before the update
    assign e2      = {err_reg[ERR_W-1], err_reg} <<< 1;
    assign dx_ext  = {{(ERR_W+1-COORD_W){1'b0}}, dx_reg};
    assign mdy_ext = -{{(ERR_W+1-COORD_W){1'b0}}, dy_reg};
    assign go_x    = $signed(e2) > $signed(mdy_ext);
    assign go_y    = $signed(e2) < $signed(dx_ext);

    always_comb
    begin
        err_next = err_reg;
        if (go_x)
        begin
            err_next = err_next - {{(ERR_W-COORD_W){1'b0}}, dy_reg};
        end
        if (go_y)
        begin
            err_next = err_next + {{(ERR_W-COORD_W){1'b0}}, dx_reg};
        end
    end

    assign stat.on_screen  = !x_reg[7] && (x_reg[6:0] < 7'(SCREEN_WIDTH))
                          && !y_reg[7] && (y_reg[6:0] < 7'(SCREEN_HEIGHT));
    assign stat.at_end     = (x_reg == xe_reg) && (y_reg == ye_reg);
    assign stat.pend_valid = pend_valid_reg;
    assign slot_free       = !out_valid_reg || m_tready;
    assign stat.slot_free  = slot_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg      <= in_sx;
            y_reg      <= in_sy;
            xe_reg     <= in_ex;
            ye_reg     <= in_ey;
            dx_reg     <= dx_load;
            dy_reg     <= dy_load;
            sx_neg_reg <= !($signed(in_sx) < $signed(in_ex));
            sy_neg_reg <= !($signed(in_sy) < $signed(in_ey));
            err_reg    <= {{(ERR_W-COORD_W){1'b0}}, dx_load}
                        - {{(ERR_W-COORD_W){1'b0}}, dy_load};
            color_reg  <= s_tdata[55:32];
        end
        else if (cmd.step)
        begin
            if (go_x)
            begin
                x_reg <= x_reg + (sx_neg_reg ? {COORD_W{1'b1}} : COORD_W'(1));
            end
            if (go_y)
            begin
                y_reg <= y_reg + (sy_neg_reg ? {COORD_W{1'b1}} : COORD_W'(1));
            end
            err_reg <= err_next;
        end
        if (cmd.take)
        begin
            pend_xy_reg <= {y_reg[4:0], x_reg[5:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            pend_valid_reg <= 1'b1;
        end
    end

    // output register: loaded only when the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_pend || cmd.flush)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_pend)
        begin
            out_data_reg <= {5'b0, color_reg, pend_xy_reg};
            out_user_reg <= 1'b1;
            out_last_reg <= 1'b0;
        end
        else if (cmd.flush)
        begin
            out_data_reg <= pend_valid_reg ? {5'b0, color_reg, pend_xy_reg} : '0;
            out_user_reg <= pend_valid_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/clipped_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// Bresenham line walker clipped to the display window.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one line request per beat: two signed endpoints and
//   a colour. Master stream gives one beat per on-screen pixel of the line,
//   in walk order from the first endpoint to the second; tlast marks the
//   final beat of a line. A line with no pixel on screen gives a single beat
//   with tuser (visible) low, tlast high and tdata zero.
// Timing:
//   One request is in work at a time. s_tready is high only between lines.
//   The Bresenham stepper visits one pixel per cycle while not stalled,
//   after the load in idle and before the flush. The first beat appears once
//   a second visible pixel is found (or at the flush), since each pixel is
//   held back until the next visible pixel to learn whether it is the last.
// Stall:
//   One output register; while it is full and not taken the stepper halts
//   on the next visible pixel and resumes without loss.
// Reset:
//   rst_n clears the controller and the valid flags; any line in work is lost.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer
    import clr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // start_x, start_y, end_x, end_y, color_red, color_green, color_blue
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, zero fill
    output logic [OUT_W-1:0]  m_tdata,
    // visible
    output logic              m_tuser,
    // last_pixel
    output logic              m_tlast,
    output logic              m_tvalid,
    input  logic              m_tready
);

    clr_cmd_t  cmd;
    clr_stat_t stat;

    clr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    clr_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== src/clr_checker.sv =====
// ----------------------------------------------------------------------------
// clr_checker
// Port-level checks of the rasteriser, bound to the top level.
// ----------------------------------------------------------------------------
`include "clipped_line_rasterizer_assert.svh"

module clr_checker
    import clr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    input  logic              m_tuser,
    input  logic              m_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready
);

    // held beat must stay valid and keep its data and last flag
    `CLR_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled beat changed")

    // an empty line is a single closing beat with no data
    `CLR_ASSERT_NOW(a_empty, clk, rst_n, m_tvalid && !m_tuser, m_tlast && (m_tdata == '0), "empty-line beat malformed")

    // one line in work at a time
    `CLR_ASSERT_NEXT(a_busy, clk, rst_n, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // every visible pixel lies in the window
    `CLR_ASSERT_NOW(a_window, clk, rst_n, m_tvalid && m_tuser, ({1'b0, m_tdata[5:0]} < 7'(SCREEN_WIDTH)) && ({2'b0, m_tdata[10:6]} < 7'(SCREEN_HEIGHT)), "pixel outside window")

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
